FILE: rtl/core/cmg_pkg.sv
package cmg_pkg;

	// Default phase resolution: one full turn is 2^ANGLE_BITS phase steps.
	localparam int ANGLE_BITS_DEF = 16;

	// Field widths fixed by the interface.
	localparam int IDX_W   = 16;
	localparam int RAD_W   = 15;
	localparam int HGT_W   = 16;
	localparam int COORD_W = 16;

	// Q30 constants for the sine evaluation.
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

	// Horner steps of the Taylor sine, each dividing by a constant through a reciprocal.
	// A multiplier of ceil(2^(32+s)/k) with s = ceil(log2 k) is exact for 32-bit operands.
	localparam int HORNER_STEPS = 6;
	localparam int RECIP_SHIFT [HORNER_STEPS] = '{40, 39, 39, 38, 37, 35};
	localparam logic [32:0] RECIP_MUL [HORNER_STEPS] = '{
		33'(((64'd1 << 40) + 64'd155) / 64'd156),
		33'(((64'd1 << 39) + 64'd109) / 64'd110),
		33'(((64'd1 << 39) + 64'd71) / 64'd72),
		33'(((64'd1 << 38) + 64'd41) / 64'd42),
		33'(((64'd1 << 37) + 64'd19) / 64'd20),
		33'(((64'd1 << 35) + 64'd5) / 64'd6)
	};

	// Order of the four sine evaluations of one segment.
	localparam logic [1:0] SLOT_ZI = 2'd0;
	localparam logic [1:0] SLOT_XI = 2'd1;
	localparam logic [1:0] SLOT_ZN = 2'd2;
	localparam logic [1:0] SLOT_XN = 2'd3;

	// Triangle kinds.
	localparam logic [1:0] KIND_SIDE_LO = 2'd0;
	localparam logic [1:0] KIND_SIDE_HI = 2'd1;
	localparam logic [1:0] KIND_TOP_CAP = 2'd2;
	localparam logic [1:0] KIND_BOT_CAP = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_RADIUS    = 2'd0;
	localparam logic [1:0] REG_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_DIVISIONS = 2'd2;

	// Tag that travels with each sine evaluation.
	typedef struct packed {
		logic       valid;
		logic [1:0] slot;
		logic       bad;
	} cmg_tag_t;

endpackage

FILE: rtl/core/cmg_div_pipe.sv
module cmg_div_pipe #(
	parameter int ANGLE_BITS = cmg_pkg::ANGLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_bad,
	input  logic [cmg_pkg::IDX_W-1:0]   idx_a,
	input  logic [cmg_pkg::IDX_W-1:0]   idx_b,
	input  logic [cmg_pkg::IDX_W-1:0]   divisor,
	output logic                        out_valid,
	output logic                        out_bad,
	output logic [ANGLE_BITS-1:0]       phase_a,
	output logic [ANGLE_BITS-1:0]       phase_b
);

	localparam int W = cmg_pkg::IDX_W;

	// Stage k holds the partial remainders and quotients after k restoring steps.
	logic [W-1:0]          rem_a_s [ANGLE_BITS+1];
	logic [W-1:0]          rem_b_s [ANGLE_BITS+1];
	logic [ANGLE_BITS-1:0] quo_a_s [ANGLE_BITS+1];
	logic [ANGLE_BITS-1:0] quo_b_s [ANGLE_BITS+1];
	logic                  vld_s   [ANGLE_BITS+1];
	logic                  bad_s   [ANGLE_BITS+1];

	assign rem_a_s[0] = idx_a;
	assign rem_b_s[0] = idx_b;
	assign quo_a_s[0] = '0;
	assign quo_b_s[0] = '0;
	assign vld_s[0]   = in_valid;
	assign bad_s[0]   = in_bad;

	// One quotient bit per stage for each of the two lanes.
	for (genvar k = 0; k < ANGLE_BITS; k++) begin : g_step
		logic [W:0] dbl_a;
		logic [W:0] dbl_b;
		logic       ge_a;
		logic       ge_b;

		assign dbl_a = {rem_a_s[k], 1'b0};
		assign dbl_b = {rem_b_s[k], 1'b0};
		assign ge_a  = dbl_a >= {1'b0, divisor};
		assign ge_b  = dbl_b >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_a_s[k+1] <= ge_a ? W'(dbl_a - {1'b0, divisor}) : W'(dbl_a);
			rem_b_s[k+1] <= ge_b ? W'(dbl_b - {1'b0, divisor}) : W'(dbl_b);
			quo_a_s[k+1] <= {quo_a_s[k][ANGLE_BITS-2:0], ge_a};
			quo_b_s[k+1] <= {quo_b_s[k][ANGLE_BITS-2:0], ge_b};
			bad_s[k+1]   <= bad_s[k];
		end
	end

	assign out_valid = vld_s[ANGLE_BITS];
	assign out_bad   = bad_s[ANGLE_BITS];
	assign phase_a   = quo_a_s[ANGLE_BITS];
	assign phase_b   = quo_b_s[ANGLE_BITS];

endmodule

FILE: rtl/core/cmg_fan.sv
module cmg_fan #(
	parameter int ANGLE_BITS = cmg_pkg::ANGLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_bad,
	input  logic [ANGLE_BITS-1:0] phase_i,
	input  logic [ANGLE_BITS-1:0] phase_n,
	output logic [ANGLE_BITS-1:0] phase,
	output cmg_pkg::cmg_tag_t     tag
);

	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	logic [ANGLE_BITS-1:0] pi_q;
	logic [ANGLE_BITS-1:0] pn_q;
	logic                  bad_q;
	logic [1:0]            cnt_q;
	logic                  run_q;

	// Hold one segment's phases and walk through its four evaluations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (in_valid) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 2'd1;
			run_q <= (cnt_q != cmg_pkg::SLOT_XN);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			pi_q  <= phase_i;
			pn_q  <= phase_n;
			bad_q <= in_bad;
		end
	end

	// Cosine is the sine a quarter turn on.
	always_comb begin
		unique case (cnt_q)
			cmg_pkg::SLOT_ZI: phase = pi_q;
			cmg_pkg::SLOT_XI: phase = pi_q + QUARTER;
			cmg_pkg::SLOT_ZN: phase = pn_q;
			cmg_pkg::SLOT_XN: phase = pn_q + QUARTER;
			default:          phase = pi_q;
		endcase
	end

	assign tag.valid = run_q;
	assign tag.slot  = cnt_q;
	assign tag.bad   = bad_q;

endmodule

FILE: rtl/core/cmg_sine_pipe.sv
module cmg_sine_pipe #(
	parameter int ANGLE_BITS = cmg_pkg::ANGLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ANGLE_BITS-1:0]             phase,
	input  cmg_pkg::cmg_tag_t                 tag_in,
	input  logic [cmg_pkg::RAD_W-1:0]         radius,
	output logic signed [cmg_pkg::COORD_W-1:0] coord,
	output cmg_pkg::cmg_tag_t                 tag_out
);

	localparam int FB = ANGLE_BITS - 2;
	localparam int PW = FB + 32;
	localparam int NS = cmg_pkg::HORNER_STEPS;
	localparam int HS = 2 * NS;
	localparam logic [FB:0] QUARTER = {1'b1, {FB{1'b0}}};

	// Stage 1: fold the phase into a quarter-turn fraction.
	logic [FB:0]       qraw;
	logic [FB:0]       qsel;
	logic [FB:0]       qf_s1;
	logic              neg_s1;
	cmg_pkg::cmg_tag_t tag_s1;

	assign qraw = {1'b0, phase[FB-1:0]};
	assign qsel = phase[FB] ? QUARTER - qraw : qraw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		qf_s1  <= qsel;
		neg_s1 <= phase[FB+1];
	end

	// Stage 2: angle in radians, Q30, rounded.
	logic [PW-1:0]     th_prod;
	logic [30:0]       theta_s2;
	logic              neg_s2;
	cmg_pkg::cmg_tag_t tag_s2;

	assign th_prod = PW'(qf_s1) * PW'(cmg_pkg::HALF_PI_Q30) + (PW'(1) << (FB - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		theta_s2 <= th_prod[FB+30:FB];
		neg_s2   <= neg_s1;
	end

	// Stage 3 (index 0 below): square of the angle, rounded.
	logic [62:0]       sq;
	logic [31:0]       x2_s    [HS+1];
	logic [30:0]       theta_s [HS+1];
	logic              neg_s   [HS+1];
	cmg_pkg::cmg_tag_t tag_s   [HS+1];

	assign sq = 63'(theta_s2) * 63'(theta_s2) + (63'(1) << 29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else begin
			tag_s[0] <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		x2_s[0]    <= sq[61:30];
		theta_s[0] <= theta_s2;
		neg_s[0]   <= neg_s2;
	end

	// The angle, its square and the tag ride alongside the Horner stages.
	for (genvar m = 0; m < HS; m++) begin : g_carry
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[m+1] <= '0;
			end else begin
				tag_s[m+1] <= tag_s[m];
			end
		end

		always_ff @(posedge clk) begin
			x2_s[m+1]    <= x2_s[m];
			theta_s[m+1] <= theta_s[m];
			neg_s[m+1]   <= neg_s[m];
		end
	end

	// Horner steps: multiply by x^2, then divide by a constant through its reciprocal.
	logic [31:0] v_s [NS];
	logic [30:0] t_s [1:NS];

	for (genvar j = 0; j < NS; j++) begin : g_horner
		logic [30:0] t_in;
		logic [63:0] mprod;
		logic [64:0] rprod;
		logic [32:0] dq;

		if (j == 0) begin : g_first
			assign t_in = cmg_pkg::Q30_ONE;
		end else begin : g_next
			assign t_in = t_s[j];
		end

		assign mprod = 64'(x2_s[2*j]) * 64'(t_in);
		assign rprod = 65'(v_s[j]) * 65'(cmg_pkg::RECIP_MUL[j]);
		assign dq    = 33'(rprod >> cmg_pkg::RECIP_SHIFT[j]);

		always_ff @(posedge clk) begin
			v_s[j]   <= mprod[61:30];
			t_s[j+1] <= (dq >= 33'(cmg_pkg::Q30_ONE)) ? '0 : 31'(33'(cmg_pkg::Q30_ONE) - dq);
		end
	end

	// Final sine value, clamped to one.
	logic [61:0]       s_prod;
	logic [30:0]       s_s16;
	logic              neg_s16;
	cmg_pkg::cmg_tag_t tag_s16;

	assign s_prod = 62'(theta_s[HS]) * 62'(t_s[NS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s16 <= '0;
		end else begin
			tag_s16 <= tag_s[HS];
		end
	end

	always_ff @(posedge clk) begin
		s_s16   <= (s_prod[61:30] > 32'(cmg_pkg::Q30_ONE)) ? cmg_pkg::Q30_ONE
			: s_prod[60:30];
		neg_s16 <= neg_s[HS];
	end

	// Scale by the radius with rounding; the magnitude never exceeds the radius.
	logic [46:0]               r_prod;
	logic [cmg_pkg::RAD_W-1:0] mag_s17;
	logic                      neg_s17;
	cmg_pkg::cmg_tag_t         tag_s17;

	assign r_prod = 47'(radius) * 47'(s_s16) + (47'(1) << 29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s17 <= '0;
		end else begin
			tag_s17 <= tag_s16;
		end
	end

	always_ff @(posedge clk) begin
		mag_s17 <= r_prod[44:30];
		neg_s17 <= neg_s16;
	end

	// Apply the quadrant sign.
	logic signed [cmg_pkg::COORD_W-1:0] coord_s18;
	cmg_pkg::cmg_tag_t                  tag_s18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s18 <= '0;
		end else begin
			tag_s18 <= tag_s17;
		end
	end

	always_ff @(posedge clk) begin
		coord_s18 <= neg_s17 ? -$signed({1'b0, mag_s17}) : $signed({1'b0, mag_s17});
	end

	assign coord   = coord_s18;
	assign tag_out = tag_s18;

endmodule

FILE: rtl/core/cmg_emit.sv
module cmg_emit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [cmg_pkg::COORD_W-1:0] coord,
	input  cmg_pkg::cmg_tag_t                  tag,
	input  logic [cmg_pkg::HGT_W-2:0]          half,
	output logic                               strobe,
	output logic [1:0]                         triangle_kind,
	output logic signed [cmg_pkg::COORD_W-1:0] ax,
	output logic signed [cmg_pkg::COORD_W-1:0] ay,
	output logic signed [cmg_pkg::COORD_W-1:0] az,
	output logic signed [cmg_pkg::COORD_W-1:0] bx,
	output logic signed [cmg_pkg::COORD_W-1:0] by_coord,
	output logic signed [cmg_pkg::COORD_W-1:0] bz,
	output logic signed [cmg_pkg::COORD_W-1:0] cx,
	output logic signed [cmg_pkg::COORD_W-1:0] cy,
	output logic signed [cmg_pkg::COORD_W-1:0] cz,
	output logic                               bad_index,
	output logic                               last_of_segment
);

	localparam int CW = cmg_pkg::COORD_W;

	// Collect the first three coordinates of a segment as they arrive.
	logic signed [CW-1:0] zi_q, xi_q, zn_q;
	logic signed [CW-1:0] szi_q, sxi_q, szn_q, sxn_q;
	logic                 sbad_q;
	logic                 run_q;
	logic [1:0]           kind_q;
	logic                 load;

	assign load = tag.valid && (tag.slot == cmg_pkg::SLOT_XN);

	always_ff @(posedge clk) begin
		if (tag.valid) begin
			unique case (tag.slot)
				cmg_pkg::SLOT_ZI: zi_q <= coord;
				cmg_pkg::SLOT_XI: xi_q <= coord;
				cmg_pkg::SLOT_ZN: zn_q <= coord;
				cmg_pkg::SLOT_XN: begin
					szi_q  <= zi_q;
					sxi_q  <= xi_q;
					szn_q  <= zn_q;
					sxn_q  <= coord;
					sbad_q <= tag.bad;
				end
				default: zi_q <= zi_q;
			endcase
		end
	end

	// Sequence the triangles of a complete segment, one per cycle; a bad segment gives a single word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			kind_q <= '0;
		end else if (load) begin
			run_q  <= 1'b1;
			kind_q <= cmg_pkg::KIND_SIDE_LO;
		end else if (run_q) begin
			kind_q <= kind_q + 2'd1;
			run_q  <= !sbad_q && (kind_q != cmg_pkg::KIND_BOT_CAP);
		end
	end

	// Assemble the vertices of the current triangle.
	logic signed [CW-1:0] ph, nh;
	logic signed [CW-1:0] v [9];
	logic                 last_c;

	assign ph = $signed({1'b0, half});
	assign nh = -ph;

	always_comb begin
		last_c = sbad_q || (kind_q == cmg_pkg::KIND_BOT_CAP);
		if (sbad_q) begin
			for (int k = 0; k < 9; k++) begin
				v[k] = '0;
			end
		end else begin
			unique case (kind_q)
				cmg_pkg::KIND_SIDE_LO: v = '{sxi_q, ph, szi_q, sxi_q, nh, szi_q, sxn_q, nh, szn_q};
				cmg_pkg::KIND_SIDE_HI: v = '{sxi_q, ph, szi_q, sxn_q, nh, szn_q, sxn_q, ph, szn_q};
				cmg_pkg::KIND_TOP_CAP: v = '{'0, ph, '0, sxi_q, ph, szi_q, sxn_q, ph, szn_q};
				cmg_pkg::KIND_BOT_CAP: v = '{'0, nh, '0, sxi_q, nh, szi_q, sxn_q, nh, szn_q};
				default:               v = '{default: '0};
			endcase
		end
	end

	// Output register: each word is shown for exactly one cycle.
	logic                 strobe_q;
	logic [1:0]           okind_q;
	logic signed [CW-1:0] ov_q [9];
	logic                 obad_q;
	logic                 olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		okind_q <= sbad_q ? cmg_pkg::KIND_SIDE_LO : kind_q;
		ov_q    <= v;
		obad_q  <= sbad_q;
		olast_q <= last_c;
	end

	assign strobe          = strobe_q;
	assign triangle_kind   = okind_q;
	assign ax              = ov_q[0];
	assign ay              = ov_q[1];
	assign az              = ov_q[2];
	assign bx              = ov_q[3];
	assign by_coord        = ov_q[4];
	assign bz              = ov_q[5];
	assign cx              = ov_q[6];
	assign cy              = ov_q[7];
	assign cz              = ov_q[8];
	assign bad_index       = obad_q;
	assign last_of_segment = olast_q;

endmodule

FILE: rtl/core/cylinder_mesh_generator_top.sv
// Channel   | Handshake                         | Word
// ----------+-----------------------------------+-----------------------------------------
// input     | start high while busy low         | segment_index
// result    | result_strobe, one cycle per word | triangle_kind, vertices, flags
// config    | APB write, psel&penable&pwrite    | radius @0x0, height @0x4, divisions @0x8
//
// Busy rises after each accepted segment index and holds off the next one.
// The four triangle words follow back to back once the index has passed the input stage,
// the divider, the fan, the sine pipeline and the triangle assembly.
// A bad index yields one flagged word. Reset touches control and config state only.
// Results cannot be held off, so nothing inside ever stalls.
module cylinder_mesh_generator_top #(
	parameter int ANGLE_BITS = cmg_pkg::ANGLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [3:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic [cmg_pkg::IDX_W-1:0]          segment_index,
	output logic                               result_strobe,
	output logic [1:0]                         triangle_kind,
	output logic signed [cmg_pkg::COORD_W-1:0] ax,
	output logic signed [cmg_pkg::COORD_W-1:0] ay,
	output logic signed [cmg_pkg::COORD_W-1:0] az,
	output logic signed [cmg_pkg::COORD_W-1:0] bx,
	output logic signed [cmg_pkg::COORD_W-1:0] by_coord,
	output logic signed [cmg_pkg::COORD_W-1:0] bz,
	output logic signed [cmg_pkg::COORD_W-1:0] cx,
	output logic signed [cmg_pkg::COORD_W-1:0] cy,
	output logic signed [cmg_pkg::COORD_W-1:0] cz,
	output logic                               bad_index,
	output logic                               last_of_segment
);

	localparam int IW = cmg_pkg::IDX_W;

	// Configuration registers.
	logic [cmg_pkg::RAD_W-1:0] radius_q;
	logic [cmg_pkg::HGT_W-1:0] height_q;
	logic [IW-1:0]             divisions_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= 15'd256;
			height_q    <= 16'd512;
			divisions_q <= 16'd16;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				cmg_pkg::REG_RADIUS:    radius_q    <= pwdata[cmg_pkg::RAD_W-1:0];
				cmg_pkg::REG_HEIGHT:    height_q    <= pwdata[cmg_pkg::HGT_W-1:0];
				cmg_pkg::REG_DIVISIONS: divisions_q <= pwdata[IW-1:0];
				default:                radius_q    <= radius_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			cmg_pkg::REG_RADIUS:    prdata = 32'(radius_q);
			cmg_pkg::REG_HEIGHT:    prdata = 32'(height_q);
			cmg_pkg::REG_DIVISIONS: prdata = 32'(divisions_q);
			default:                prdata = '0;
		endcase
	end

	// Input spacing: busy holds off the next index after each accepted one.
	logic [1:0] gap_q;
	logic       accept;

	assign busy   = (gap_q != 2'd0);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
		end else if (accept) begin
			gap_q <= 2'd3;
		end else if (busy) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// Input stage: range check and the wrapped next index.
	logic [IW:0]   inc;
	logic [IW-1:0] idx_s1;
	logic [IW-1:0] nxt_s1;
	logic          bad_s1;
	logic          vld_s1;

	assign inc = {1'b0, segment_index} + (IW+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= segment_index;
			nxt_s1 <= (inc < {1'b0, divisions_q}) ? inc[IW-1:0] : '0;
			bad_s1 <= (segment_index >= divisions_q);
		end
	end

	// Phase division for both circle points.
	logic                  dv_valid;
	logic                  dv_bad;
	logic [ANGLE_BITS-1:0] ph_i;
	logic [ANGLE_BITS-1:0] ph_n;

	cmg_div_pipe #(.ANGLE_BITS(ANGLE_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_bad    (bad_s1),
		.idx_a     (idx_s1),
		.idx_b     (nxt_s1),
		.divisor   (divisions_q),
		.out_valid (dv_valid),
		.out_bad   (dv_bad),
		.phase_a   (ph_i),
		.phase_b   (ph_n)
	);

	// Four sine evaluations per segment through one shared pipeline.
	logic [ANGLE_BITS-1:0]              fan_phase;
	cmg_pkg::cmg_tag_t                  fan_tag;
	logic signed [cmg_pkg::COORD_W-1:0] sn_coord;
	cmg_pkg::cmg_tag_t                  sn_tag;

	cmg_fan #(.ANGLE_BITS(ANGLE_BITS)) u_fan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv_valid),
		.in_bad   (dv_bad),
		.phase_i  (ph_i),
		.phase_n  (ph_n),
		.phase    (fan_phase),
		.tag      (fan_tag)
	);

	cmg_sine_pipe #(.ANGLE_BITS(ANGLE_BITS)) u_sine (
		.clk     (clk),
		.arst_n  (arst_n),
		.phase   (fan_phase),
		.tag_in  (fan_tag),
		.radius  (radius_q),
		.coord   (sn_coord),
		.tag_out (sn_tag)
	);

	// Triangle assembly and result output.
	cmg_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.coord           (sn_coord),
		.tag             (sn_tag),
		.half            (height_q[cmg_pkg::HGT_W-1:1]),
		.strobe          (result_strobe),
		.triangle_kind   (triangle_kind),
		.ax              (ax),
		.ay              (ay),
		.az              (az),
		.bx              (bx),
		.by_coord        (by_coord),
		.bz              (bz),
		.cx              (cx),
		.cy              (cy),
		.cz              (cz),
		.bad_index       (bad_index),
		.last_of_segment (last_of_segment)
	);

endmodule

FILE: rtl/core/cmg_checker.sv
module cmg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_strobe,
	input logic [1:0] triangle_kind,
	input logic       bad_index,
	input logic       last_of_segment
);

	// An accepted index holds off the next one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted index");

	// An error word is a lone kind-zero word.
	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && bad_index |-> last_of_segment
			&& (triangle_kind == cmg_pkg::KIND_SIDE_LO))
		else $error("error word not marked as last");

	// Words of one segment follow back to back in kind order.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_of_segment |=> result_strobe
			&& (triangle_kind == 2'($past(triangle_kind) + 2'd1)))
		else $error("segment words not consecutive");

	// The bottom cap closes a segment.
	a_cap_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (triangle_kind == cmg_pkg::KIND_BOT_CAP) |-> last_of_segment)
		else $error("bottom cap word not marked as last");

endmodule

bind cylinder_mesh_generator_top cmg_checker u_chk (.*);
